/* hw/rtl/pbwfe_pkg.sv */
// Shared types, codes and length helpers for the protobuf wire field encoder.
`timescale 1ns / 1ps

package pbwfe_pkg;

	localparam int TAG_SHIFT        = 3;
	localparam int MAX_VARINT_BYTES = 10;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		REQ_VARINT      = 3'd0,
		REQ_FIXED64     = 3'd1,
		REQ_LENGTH      = 3'd2,
		REQ_GROUP_START = 3'd3,
		REQ_GROUP_END   = 3'd4,
		REQ_FIXED32     = 3'd5,
		REQ_PAYLOAD     = 3'd6
	} req_code_t;

	// One classified item: a tag varint followed by a body of varint or raw bytes.
	typedef struct packed {
		logic [31:0] tag;
		logic [2:0]  tag_len;   // 0 for a payload byte
		logic [63:0] body;
		logic [3:0]  body_len;  // 0 when only the tag is sent
		logic        body_var;  // body is a varint (7 bits a byte)
	} job_t;

	// Bytes of a 64-bit varint: one plus the index of the highest nonzero 7-bit group (the lowest group is index 0).
	function automatic logic [3:0] varint_len64(input logic [63:0] v);
		logic [3:0] len;
		len = 4'd1;
		for (int k = 1; k < MAX_VARINT_BYTES; k++) begin
			if ((v >> (7 * k)) != 64'd0) begin
				len = 4'(k + 1);
			end
		end
		return len;
	endfunction

	function automatic logic [2:0] varint_len32(input logic [31:0] v);
		logic [2:0] len;
		len = 3'd1;
		for (int k = 1; k < 5; k++) begin
			if ((v >> (7 * k)) != 32'd0) begin
				len = 3'(k + 1);
			end
		end
		return len;
	endfunction

endpackage

/* hw/rtl/pbwfe_if.sv */
// Valid/ready channel interfaces for request items and wire bytes.
`timescale 1ns / 1ps

interface pbwfe_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [28:0] field_number;
	logic [63:0] value;
	logic [30:0] data_length;
	logic [7:0]  data_byte;

	modport source (output valid, req_type, field_number, value, data_length, data_byte,
		input ready);
	modport sink (input valid, req_type, field_number, value, data_length, data_byte,
		output ready);
endinterface

interface pbwfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface

/* hw/rtl/pbwfe_front.sv */
// Front end: accept request beats and classify them into tag/body jobs.
`timescale 1ns / 1ps

module pbwfe_front (
	pbwfe_req_if.sink          item,
	output pbwfe_pkg::job_t    job,
	output logic               job_valid,
	input  logic               job_ready
);
	import pbwfe_pkg::*;

	logic [31:0] tag;

	assign item.ready = job_ready;
	assign tag = ({3'd0, item.field_number} << TAG_SHIFT) | {29'd0, item.req_type};

	always_comb begin
		job.tag      = tag;
		job.tag_len  = varint_len32(tag);
		job.body     = item.value;
		job.body_len = 4'd0;
		job.body_var = 1'b0;
		job_valid    = item.valid;
		case (req_code_t'(item.req_type))
			REQ_VARINT: begin
				job.body_len = varint_len64(item.value);
				job.body_var = 1'b1;
			end
			REQ_FIXED64: begin
				job.body_len = 4'd8;
			end
			REQ_LENGTH: begin
				job.body     = {33'd0, item.data_length};
				job.body_len = varint_len64({33'd0, item.data_length});
				job.body_var = 1'b1;
			end
			REQ_GROUP_START, REQ_GROUP_END: begin
				job.body_len = 4'd0;
			end
			REQ_FIXED32: begin
				job.body     = {32'd0, item.value[31:0]};
				job.body_len = 4'd4;
			end
			REQ_PAYLOAD: begin
				job.tag_len  = 3'd0;
				job.body     = {56'd0, item.data_byte};
				job.body_len = 4'd1;
			end
			default: begin
				// unused code: accept and drop
				job_valid = 1'b0;
			end
		endcase
	end

endmodule

/* hw/rtl/pbwfe_queue.sv */
// Small job queue between the front and back ends.
`timescale 1ns / 1ps

module pbwfe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  pbwfe_pkg::job_t    push_job,
	input  logic               push_valid,
	output logic               push_ready,
	output pbwfe_pkg::job_t    pop_job,
	output logic               pop_valid,
	input  logic               pop_ready
);
	import pbwfe_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* hw/rtl/pbwfe_back.sv */
// Back end: serialize one job a byte per cycle, while the stream is ready, into a registered output.
`timescale 1ns / 1ps

module pbwfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pbwfe_pkg::job_t    job,
	input  logic               job_valid,
	output logic               job_ready,
	pbwfe_byte_if.source       stream
);
	import pbwfe_pkg::*;

	logic        cur_valid_q;
	logic [31:0] tag_q;
	logic [2:0]  tag_left_q;
	logic [63:0] body_q;
	logic [3:0]  body_left_q;
	logic        body_var_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic        load;

	always_comb begin
		if (tag_left_q != 3'd0) begin
			emit_byte = {(tag_left_q != 3'd1), tag_q[6:0]};
			emit_last = (tag_left_q == 3'd1) && (body_left_q == 4'd0);
		end else if (body_var_q) begin
			emit_byte = {(body_left_q != 4'd1), body_q[6:0]};
			emit_last = (body_left_q == 4'd1);
		end else begin
			emit_byte = body_q[7:0];
			emit_last = (body_left_q == 4'd1);
		end
	end

	assign emit      = cur_valid_q && (!out_valid_q || stream.ready);
	assign load      = job_valid && (!cur_valid_q || (emit && emit_last));
	assign job_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
			end else if (emit && emit_last) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
		if (load) begin
			tag_q       <= job.tag;
			tag_left_q  <= job.tag_len;
			body_q      <= job.body;
			body_left_q <= job.body_len;
			body_var_q  <= job.body_var;
		end else if (emit) begin
			if (tag_left_q != 3'd0) begin
				tag_q      <= tag_q >> 7;
				tag_left_q <= tag_left_q - 3'd1;
			end else begin
				body_q      <= body_var_q ? (body_q >> 7) : (body_q >> 8);
				body_left_q <= body_left_q - 4'd1;
			end
		end
	end

	assign stream.valid     = out_valid_q;
	assign stream.out_byte  = out_byte_q;
	assign stream.last_byte = out_last_q;

endmodule

/* hw/rtl/protobuf_wire_field_encoder.sv */
// Top level of the protobuf wire field encoder: front, job queue and serializer.
`timescale 1ns / 1ps

// Usage:
//   item   - request channel. Each beat is one field description (varint, fixed32,
//            fixed64, length header, group start or group end) or one payload byte,
//            selected by req_type. Code 7 is accepted and produces nothing.
//   stream - wire channel. Each beat is one serialized byte; last_byte marks the final
//            byte produced for a request beat.
// Throughput: the serializer sends one byte per cycle while stream.ready is high, and a
//   request has 1 wire byte for a payload byte and up to 15 for a varint field.
//   Payload bytes likewise stream at one per cycle; header items hold the request
//   channel only once the four-entry job queue fills while their bytes drain.
// Path: an accepted beat is written into the job queue, then loaded into the serializer
//   and registered in the output register before its first byte shows on stream.
// Stall: when stream.ready is low the output register holds its byte, the serializer
//   waits, and the job queue absorbs up to four more request beats before item.ready
//   drops.
// Reset: arst_n clears the queue, the serializer and the output valid; no byte is in
//   flight afterward and no state is carried between requests.
module protobuf_wire_field_encoder (
	input  logic          clk,
	input  logic          arst_n,
	pbwfe_req_if.sink     item,
	pbwfe_byte_if.source  stream
);
	import pbwfe_pkg::*;

	job_t front_job;
	logic front_valid;
	logic front_ready;
	job_t back_job;
	logic back_valid;
	logic back_ready;

	// Classify each request beat into a tag plus body job.
	pbwfe_front u_front (
		.item      (item),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	// Decouple classification from serialization.
	pbwfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// Emit one wire byte per cycle while the stream is ready; advance to the next job on the last byte.
	pbwfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.stream    (stream)
	);

endmodule
